### design/acpn_pkg.sv
// Shared types, constants and helpers for the box closest-point pipeline.
`default_nettype none

package acpn_pkg;

    // Coordinate width and the derived widths.
    localparam int CoordBits = 32;
    localparam int DiffBits  = CoordBits + 1;
    localparam int InBits    = ((3 * CoordBits + 7) / 8) * 8;
    localparam int OutFields = 3 * CoordBits + 4;
    localparam int OutBits   = ((OutFields + 7) / 8) * 8;
    localparam int CfgIdxBits = 3;
    localparam int FaceBits  = 3;

    typedef logic [CoordBits-1:0] t_coord;
    typedef logic [DiffBits-1:0]  t_diff;
    typedef logic [FaceBits-1:0]  t_face;
    typedef t_coord [2:0]         t_vec;

    // Face codes, in tie-break order.
    localparam t_face FacePosX = 3'd0;
    localparam t_face FacePosY = 3'd1;
    localparam t_face FacePosZ = 3'd2;
    localparam t_face FaceNegX = 3'd3;
    localparam t_face FaceNegY = 3'd4;
    localparam t_face FaceNegZ = 3'd5;

    // Configuration register indexes.
    localparam logic [CfgIdxBits-1:0] RegLowerX = 3'd0;
    localparam logic [CfgIdxBits-1:0] RegLowerY = 3'd1;
    localparam logic [CfgIdxBits-1:0] RegLowerZ = 3'd2;
    localparam logic [CfgIdxBits-1:0] RegUpperX = 3'd3;
    localparam logic [CfgIdxBits-1:0] RegUpperY = 3'd4;
    localparam logic [CfgIdxBits-1:0] RegUpperZ = 3'd5;

    // Upper corner after reset: 1.0 in Q16.16.
    localparam t_coord UpperReset = t_coord'(65536);

    typedef struct packed {
        t_vec lo;
        t_vec hi;
    } t_box;

    // After the difference stage.
    typedef struct packed {
        t_vec        p;
        t_diff [2:0] dhi;
        t_diff [2:0] dlo;
    } t_s1;

    // After the clamp and score stage; keys are maximised.
    typedef struct packed {
        t_vec        p;
        t_vec        nr;
        logic        in_box;
        t_diff [5:0] key;
    } t_s2;

    // After the pairwise compare.
    typedef struct packed {
        t_vec        p;
        t_vec        nr;
        logic        in_box;
        t_diff [2:0] wkey;
        t_face [2:0] wface;
    } t_s3;

    // After merging the first two pairs.
    typedef struct packed {
        t_vec  p;
        t_vec  nr;
        logic  in_box;
        t_diff abkey;
        t_face abface;
        t_diff ckey;
        t_face cface;
    } t_s4;

    // Sign-extend a coordinate by one bit.
    function automatic t_diff sx(input t_coord v);
        sx = {v[CoordBits-1], v};
    endfunction

endpackage

`default_nettype wire

### design/aabb_closest_point_normal_top.sv
// Throughput: one point per cycle while the output is not stalled; five register
// stages (differences, clamp and keys, pair compare, pair merge, final merge into the
// output register). A stalled output holds each full stage whose next stage is full;
// nothing is dropped or repeated. Reset clears all valid flags and sets the box to the
// unit cube.
// Top level: box closest point and face normal, configuration registers, output stage.
`default_nettype none

module aabb_closest_point_normal_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // Configuration write port
    input  wire logic                                 i_cfg_we,
    input  wire logic [acpn_pkg::CfgIdxBits-1:0]      i_cfg_idx,
    input  wire logic [acpn_pkg::CoordBits-1:0]       i_cfg_data,
    // Input stream
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // point_x, point_y, point_z (lowest bit up)
    input  wire logic [acpn_pkg::InBits-1:0]          s_axis_tdata,
    // Output stream
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // near_x, near_y, near_z, face_code, was_inside, zero pad (lowest bit up)
    output logic [acpn_pkg::OutBits-1:0]              m_axis_tdata
);

    localparam int Cb = acpn_pkg::CoordBits;

    acpn_pkg::t_box   r_box;
    acpn_pkg::t_vec   point;
    logic             v1;
    logic             v2;
    logic             v4;
    logic             rdy1;
    logic             rdy2;
    logic             rdy4;
    logic             out_ready;
    acpn_pkg::t_s1    s1;
    acpn_pkg::t_s2    s2;
    acpn_pkg::t_s4    s4;
    logic             r_ov;
    acpn_pkg::t_vec   r_near;
    acpn_pkg::t_face  r_face;
    logic             r_inside;
    acpn_pkg::t_vec   n_near;
    acpn_pkg::t_face  n_face;

    // Write the box corners.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box.lo <= '0;
            r_box.hi <= {acpn_pkg::UpperReset, acpn_pkg::UpperReset, acpn_pkg::UpperReset};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                acpn_pkg::RegLowerX: r_box.lo[0] <= i_cfg_data;
                acpn_pkg::RegLowerY: r_box.lo[1] <= i_cfg_data;
                acpn_pkg::RegLowerZ: r_box.lo[2] <= i_cfg_data;
                acpn_pkg::RegUpperX: r_box.hi[0] <= i_cfg_data;
                acpn_pkg::RegUpperY: r_box.hi[1] <= i_cfg_data;
                acpn_pkg::RegUpperZ: r_box.hi[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack the input beat.
    assign point[0] = s_axis_tdata[Cb-1:0];
    assign point[1] = s_axis_tdata[2*Cb-1:Cb];
    assign point[2] = s_axis_tdata[3*Cb-1:2*Cb];

    acpn_diff u_diff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_point (point),
        .i_box   (r_box),
        .o_valid (v1),
        .i_ready (rdy1),
        .o_s1    (s1)
    );

    acpn_score u_score (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v1),
        .o_ready (rdy1),
        .i_s1    (s1),
        .i_box   (r_box),
        .o_valid (v2),
        .i_ready (rdy2),
        .o_s2    (s2)
    );

    acpn_select u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v2),
        .o_ready (rdy2),
        .i_s2    (s2),
        .o_valid (v4),
        .i_ready (rdy4),
        .o_s4    (s4)
    );

    assign out_ready = !r_ov || m_axis_tready;
    assign rdy4      = out_ready;

    // Final merge with the third pair, then snap an inside point to its face.
    always_comb begin
        if ($signed(s4.ckey) > $signed(s4.abkey)) begin
            n_face = s4.cface;
        end else begin
            n_face = s4.abface;
        end
        if (s4.in_box) begin
            n_near = s4.p;
            case (n_face)
                acpn_pkg::FacePosX: n_near[0] = r_box.hi[0];
                acpn_pkg::FacePosY: n_near[1] = r_box.hi[1];
                acpn_pkg::FacePosZ: n_near[2] = r_box.hi[2];
                acpn_pkg::FaceNegX: n_near[0] = r_box.lo[0];
                acpn_pkg::FaceNegY: n_near[1] = r_box.lo[1];
                acpn_pkg::FaceNegZ: n_near[2] = r_box.lo[2];
                default: ;
            endcase
        end else begin
            n_near = s4.nr;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_ready) begin
            r_ov <= v4;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (v4 && out_ready) begin
            r_near   <= n_near;
            r_face   <= n_face;
            r_inside <= s4.in_box;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = acpn_pkg::OutBits'({r_inside, r_face, r_near[2], r_near[1],
                                              r_near[0]});

    // The input side stalls only when the whole pipeline is held by the output.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while output side is free");

    // A face code is always one of the six faces.
    a_face_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_face <= acpn_pkg::FaceNegZ))
        else $error("face code out of range");

    // Nothing is offered straight after reset.
    a_reset_clears: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid after reset");

    // An inside point snapped to the +x face sits on the upper x bound.
    a_inside_on_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_inside && (r_face == acpn_pkg::FacePosX))
            |-> (r_near[0] == r_box.hi[0]))
        else $error("inside point not snapped to its face");

endmodule

`default_nettype wire

### design/acpn_diff.sv
// First stage: signed distances from the point to both corners on each axis.
`default_nettype none

module acpn_diff (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire acpn_pkg::t_vec i_point,
    input  wire acpn_pkg::t_box i_box,
    output logic               o_valid,
    input  wire logic          i_ready,
    output acpn_pkg::t_s1      o_s1
);

    logic          r_v;
    acpn_pkg::t_s1 r_s1;
    acpn_pkg::t_s1 n_s1;

    assign o_ready = !r_v || i_ready;

    // Form upper - point and point - lower at one extra bit.
    always_comb begin
        n_s1.p = i_point;
        for (int i = 0; i < 3; i++) begin
            n_s1.dhi[i] = acpn_pkg::sx(i_box.hi[i]) - acpn_pkg::sx(i_point[i]);
            n_s1.dlo[i] = acpn_pkg::sx(i_point[i]) - acpn_pkg::sx(i_box.lo[i]);
        end
    end

    // Hold the valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    // Load the payload on an accepted beat.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_s1 <= n_s1;
        end
    end

    assign o_valid = r_v;
    assign o_s1    = r_s1;

endmodule

`default_nettype wire

### design/acpn_score.sv
// Second stage: inside test, clamping and the six face keys.
`default_nettype none

module acpn_score (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire acpn_pkg::t_s1 i_s1,
    input  wire acpn_pkg::t_box i_box,
    output logic               o_valid,
    input  wire logic          i_ready,
    output acpn_pkg::t_s2      o_s2
);

    logic          r_v;
    acpn_pkg::t_s2 r_s2;
    acpn_pkg::t_s2 n_s2;
    logic [2:0]    below;
    logic [2:0]    above;
    acpn_pkg::t_diff [2:0] oscore;

    assign o_ready = !r_v || i_ready;

    // Clamp each axis and build keys so that the winner is always the largest.
    // Inside, the nearest face has the smallest distance, so negate it.
    always_comb begin
        n_s2.p = i_s1.p;
        for (int i = 0; i < 3; i++) begin
            below[i] = i_s1.dlo[i][acpn_pkg::DiffBits-1];
            above[i] = i_s1.dhi[i][acpn_pkg::DiffBits-1];
            if (below[i]) begin
                n_s2.nr[i] = i_box.lo[i];
                oscore[i]  = i_s1.dlo[i];
            end else if (above[i]) begin
                n_s2.nr[i] = i_box.hi[i];
                oscore[i]  = -i_s1.dhi[i];
            end else begin
                n_s2.nr[i] = i_s1.p[i];
                oscore[i]  = '0;
            end
        end
        n_s2.in_box = !(|below) && !(|above);
        for (int i = 0; i < 3; i++) begin
            if (n_s2.in_box) begin
                n_s2.key[i]     = -i_s1.dhi[i];
                n_s2.key[i + 3] = -i_s1.dlo[i];
            end else begin
                n_s2.key[i]     = oscore[i];
                n_s2.key[i + 3] = -oscore[i];
            end
        end
    end

    // Hold the valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    // Load the payload on an accepted beat.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_v;
    assign o_s2    = r_s2;

endmodule

`default_nettype wire

### design/acpn_select.sv
// Third and fourth stages: pairwise key compare, then merge of the first two pairs.
`default_nettype none

module acpn_select (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire acpn_pkg::t_s2 i_s2,
    output logic               o_valid,
    input  wire logic          i_ready,
    output acpn_pkg::t_s4      o_s4
);

    logic          r_v3;
    logic          r_v4;
    logic          ready3;
    logic          ready4;
    acpn_pkg::t_s3 r_s3;
    acpn_pkg::t_s3 n_s3;
    acpn_pkg::t_s4 r_s4;
    acpn_pkg::t_s4 n_s4;

    assign ready4  = !r_v4 || i_ready;
    assign ready3  = !r_v3 || ready4;
    assign o_ready = ready3;

    // Compare each pair; the later face wins only on a strictly larger key.
    always_comb begin
        n_s3.p      = i_s2.p;
        n_s3.nr     = i_s2.nr;
        n_s3.in_box = i_s2.in_box;
        for (int j = 0; j < 3; j++) begin
            if ($signed(i_s2.key[2 * j + 1]) > $signed(i_s2.key[2 * j])) begin
                n_s3.wkey[j]  = i_s2.key[2 * j + 1];
                n_s3.wface[j] = acpn_pkg::FaceBits'(2 * j + 1);
            end else begin
                n_s3.wkey[j]  = i_s2.key[2 * j];
                n_s3.wface[j] = acpn_pkg::FaceBits'(2 * j);
            end
        end
    end

    // Merge the first two pair winners; pass the third along.
    always_comb begin
        n_s4.p      = r_s3.p;
        n_s4.nr     = r_s3.nr;
        n_s4.in_box = r_s3.in_box;
        n_s4.ckey   = r_s3.wkey[2];
        n_s4.cface  = r_s3.wface[2];
        if ($signed(r_s3.wkey[1]) > $signed(r_s3.wkey[0])) begin
            n_s4.abkey  = r_s3.wkey[1];
            n_s4.abface = r_s3.wface[1];
        end else begin
            n_s4.abkey  = r_s3.wkey[0];
            n_s4.abface = r_s3.wface[0];
        end
    end

    // Advance the valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (ready3) begin
                r_v3 <= i_valid;
            end
            if (ready4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Load the payloads.
    always_ff @(posedge i_clk) begin
        if (i_valid && ready3) begin
            r_s3 <= n_s3;
        end
        if (r_v3 && ready4) begin
            r_s4 <= n_s4;
        end
    end

    assign o_valid = r_v4;
    assign o_s4    = r_s4;

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking stream testbench for the box closest-point and face-normal block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        acpn_pkg::t_vec  near;
        acpn_pkg::t_face face;
        logic            in_box;
    } t_answer;

    localparam int Cb = acpn_pkg::CoordBits;
    localparam int Fb = acpn_pkg::FaceBits;

    localparam logic [acpn_pkg::CfgIdxBits-1:0] CfgSpareA = 3'd6;
    localparam logic [acpn_pkg::CfgIdxBits-1:0] CfgSpareB = 3'd7;
    localparam logic [acpn_pkg::CfgIdxBits-1:0] LowerRegs [3] =
        '{acpn_pkg::RegLowerX, acpn_pkg::RegLowerY, acpn_pkg::RegLowerZ};
    localparam logic [acpn_pkg::CfgIdxBits-1:0] UpperRegs [3] =
        '{acpn_pkg::RegUpperX, acpn_pkg::RegUpperY, acpn_pkg::RegUpperZ};
    localparam acpn_pkg::t_face FaceOrder [6] =
        '{acpn_pkg::FacePosX, acpn_pkg::FacePosY, acpn_pkg::FacePosZ,
          acpn_pkg::FaceNegX, acpn_pkg::FaceNegY, acpn_pkg::FaceNegZ};

    localparam acpn_pkg::t_coord One     = 32'h0001_0000;
    localparam acpn_pkg::t_coord Half    = 32'h0000_8000;
    localparam acpn_pkg::t_coord Quarter = 32'h0000_4000;
    localparam acpn_pkg::t_coord MinC    = 32'h8000_0000;
    localparam acpn_pkg::t_coord MaxC    = 32'h7fff_ffff;
    localparam int     StallLimit = 4000;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [acpn_pkg::CfgIdxBits-1:0] i_cfg_idx  = '0;
    logic [Cb-1:0]      i_cfg_data    = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [acpn_pkg::InBits-1:0]  s_axis_tdata  = '0;   // point_x, point_y, point_z
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // near_x, near_y, near_z, face_code, was_inside, pad
    logic [acpn_pkg::OutBits-1:0] m_axis_tdata;

    // Mirror of the box registers and the queue of predicted answers
    acpn_pkg::t_vec box_lo;
    acpn_pkg::t_vec box_hi;
    t_answer pending_answers [$];
    int      mismatch_count = 0;
    int      src_idle_pct   = 0;
    int      snk_stall_pct  = 0;
    int      quiet_cycles   = 0;

    aabb_closest_point_normal_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Work out the nearest surface point and its face for the current box
    function automatic t_answer closest_on_box(input acpn_pkg::t_vec pt);
        logic signed [acpn_pkg::DiffBits-1:0] pv [3];
        logic signed [acpn_pkg::DiffBits-1:0] lv [3];
        logic signed [acpn_pkg::DiffBits-1:0] hv [3];
        logic signed [acpn_pkg::DiffBits-1:0] nv [3];
        logic signed [acpn_pkg::DiffBits-1:0] score [6];
        int      pick;
        t_answer ans;
        ans.in_box = 1'b1;
        for (int a = 0; a < 3; a++) begin
            pv[a] = $signed(pt[a]);
            lv[a] = $signed(box_lo[a]);
            hv[a] = $signed(box_hi[a]);
            if (pv[a] < lv[a] || pv[a] > hv[a])
                ans.in_box = 1'b0;
        end
        pick = 0;
        if (ans.in_box) begin
            // snap to the nearest face; earlier face keeps a tie
            for (int a = 0; a < 3; a++) begin
                score[a]     = hv[a] - pv[a];
                score[a + 3] = pv[a] - lv[a];
                nv[a]        = pv[a];
            end
            for (int f = 1; f < 6; f++)
                if (score[f] < score[pick])
                    pick = f;
            if (pick < 3)
                nv[pick] = hv[pick];
            else
                nv[pick - 3] = lv[pick - 3];
        end else begin
            // clamp, then take the face with the largest outward offset
            for (int a = 0; a < 3; a++) begin
                if (pv[a] < lv[a])
                    nv[a] = lv[a];
                else if (pv[a] > hv[a])
                    nv[a] = hv[a];
                else
                    nv[a] = pv[a];
                score[a]     = pv[a] - nv[a];
                score[a + 3] = nv[a] - pv[a];
            end
            for (int f = 1; f < 6; f++)
                if (score[f] > score[pick])
                    pick = f;
        end
        for (int a = 0; a < 3; a++)
            ans.near[a] = nv[a][Cb-1:0];
        ans.face = FaceOrder[pick];
        return ans;
    endfunction

    // Offer one point, idling first at the sender's rate, and hold it until taken
    task automatic send_point(input acpn_pkg::t_vec pt);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pt[2], pt[1], pt[0]};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        pending_answers.push_back(closest_on_box(pt));
    endtask

    // Drop valid, drain every outstanding answer and let the pipeline settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Write all six corner registers, then the two unused indexes with junk
    task automatic program_box(input acpn_pkg::t_vec lo, input acpn_pkg::t_vec hi);
        wait_idle();
        for (int a = 0; a < 3; a++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= LowerRegs[a];
            i_cfg_data <= lo[a];
            @(posedge i_clk);
            i_cfg_idx  <= UpperRegs[a];
            i_cfg_data <= hi[a];
            @(posedge i_clk);
        end
        i_cfg_idx  <= CfgSpareA;
        i_cfg_data <= $urandom;
        @(posedge i_clk);
        i_cfg_idx  <= CfgSpareB;
        i_cfg_data <= $urandom;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        box_lo = lo;
        box_hi = hi;
    endtask

    task automatic note_mismatch(input string what, input logic [Cb-1:0] want,
                                 input logic [Cb-1:0] got);
        mismatch_count++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
    endtask

    // Receiver stalls at its current rate
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);

    // Compare each output beat against the oldest prediction
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_answers.size() == 0) begin
                note_mismatch("unexpected beat", '0, m_axis_tdata[Cb-1:0]);
            end else begin
                want = pending_answers.pop_front();
                if (m_axis_tdata[0 +: Cb] !== want.near[0])
                    note_mismatch("near_x", want.near[0], m_axis_tdata[0 +: Cb]);
                if (m_axis_tdata[Cb +: Cb] !== want.near[1])
                    note_mismatch("near_y", want.near[1], m_axis_tdata[Cb +: Cb]);
                if (m_axis_tdata[2*Cb +: Cb] !== want.near[2])
                    note_mismatch("near_z", want.near[2], m_axis_tdata[2*Cb +: Cb]);
                if (m_axis_tdata[3*Cb +: Fb] !== want.face)
                    note_mismatch("face_code", want.face, m_axis_tdata[3*Cb +: Fb]);
                if (m_axis_tdata[3*Cb+Fb] !== want.in_box)
                    note_mismatch("was_inside", want.in_box, m_axis_tdata[3*Cb+Fb]);
                if (m_axis_tdata[acpn_pkg::OutBits-1:acpn_pkg::OutFields] !== '0)
                    note_mismatch("pad", '0,
                                  m_axis_tdata[acpn_pkg::OutBits-1:acpn_pkg::OutFields]);
            end
        end
    end

    // Watchdog: end the run when no beat moves on either side for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("** aabb_closest_point_normal_top: FAILED **");
            $finish;
        end
    end

    // Random coordinate around one axis of the box, biased to its edges
    function automatic acpn_pkg::t_coord pick_coord(input acpn_pkg::t_coord lo,
                                                    input acpn_pkg::t_coord hi,
                                                    input bit want_inside);
        longint l;
        longint h;
        longint span;
        int     mode;
        l = longint'($signed(lo));
        h = longint'($signed(hi));
        mode = want_inside ? $urandom_range(2) : $urandom_range(11);
        case (mode)
            0: return lo;
            1: return hi;
            3: return acpn_pkg::t_coord'(l - 1);
            4: return acpn_pkg::t_coord'(h + 1);
            5: return acpn_pkg::t_coord'(l + $urandom_range(3));
            6: return acpn_pkg::t_coord'(h - $urandom_range(3));
            7: return $urandom_range(1) ? MinC : MaxC;
            8, 9: return $urandom;
            default: begin
                if (h < l)
                    return $urandom;
                span = h - l + 1;
                return acpn_pkg::t_coord'(l + longint'(({$urandom, $urandom} >> 1) % span));
            end
        endcase
    endfunction

    // Random extent of one axis: full range, point-like, inverted, small or arbitrary
    task automatic pick_span(output acpn_pkg::t_coord lo, output acpn_pkg::t_coord hi);
        longint a;
        longint b;
        longint w;
        a = longint'($signed($urandom));
        b = longint'($signed($urandom));
        case ($urandom_range(9))
            0: begin
                lo = MinC;
                hi = MaxC;
            end
            1: begin
                lo = acpn_pkg::t_coord'(a);
                hi = acpn_pkg::t_coord'(a);
            end
            2: begin
                lo = acpn_pkg::t_coord'(a > b ? a : b);
                hi = acpn_pkg::t_coord'(a > b ? b : a);
            end
            3, 4, 5: begin
                w = $urandom_range(1 << 20);
                lo = acpn_pkg::t_coord'((a - w) < -(64'sd1 << 31) ? -(64'sd1 << 31) : a - w);
                hi = acpn_pkg::t_coord'((a + w) > ((64'sd1 << 31) - 1) ?
                                        (64'sd1 << 31) - 1 : a + w);
            end
            default: begin
                lo = acpn_pkg::t_coord'(a < b ? a : b);
                hi = acpn_pkg::t_coord'(a < b ? b : a);
            end
        endcase
    endtask

    // Unit cube left by reset: inside ties, corners, outside ties, extreme points
    task automatic test_reset_box();
        box_lo = '{3{acpn_pkg::t_coord'(0)}};
        box_hi = '{3{acpn_pkg::UpperReset}};
        send_point('{Half, Half, Half});
        send_point('{acpn_pkg::t_coord'(0), acpn_pkg::t_coord'(0), acpn_pkg::t_coord'(0)});
        send_point('{One, One, One});
        send_point('{Half, Half, acpn_pkg::t_coord'(2) * One});
        send_point('{Half, One + One, -acpn_pkg::t_coord'(3) * One});
        send_point('{acpn_pkg::t_coord'(2) * One, acpn_pkg::t_coord'(2) * One,
                     acpn_pkg::t_coord'(2) * One});
        send_point('{-One, Half, Half});
        send_point('{MinC, MinC, MinC});
        send_point('{MaxC, MaxC, MaxC});
    endtask

    // Box spanning the whole coordinate range: every point is inside
    task automatic test_full_range_box();
        program_box('{MinC, MinC, MinC}, '{MaxC, MaxC, MaxC});
        send_point('{MinC, MinC, MinC});
        send_point('{MaxC, MaxC, MaxC});
        send_point('{acpn_pkg::t_coord'(0), acpn_pkg::t_coord'(0), acpn_pkg::t_coord'(0)});
        send_point('{MinC, MaxC, acpn_pkg::t_coord'(-1)});
        send_point('{$urandom, $urandom, $urandom});
    endtask

    // Lower corner above the upper one: nothing is inside
    task automatic test_inverted_box();
        program_box('{One, One, One}, '{-One, -One, -One});
        send_point('{acpn_pkg::t_coord'(0), acpn_pkg::t_coord'(0), acpn_pkg::t_coord'(0)});
        send_point('{acpn_pkg::t_coord'(5) * One, acpn_pkg::t_coord'(5) * One,
                     acpn_pkg::t_coord'(5) * One});
        send_point('{MinC, MaxC, One});
    endtask

    // Box collapsed to one point
    task automatic test_point_box();
        program_box('{Quarter, Quarter, Quarter}, '{Quarter, Quarter, Quarter});
        send_point('{Quarter, Quarter, Quarter});
        send_point('{Quarter + 1, Quarter, Quarter - 1});
        send_point('{MaxC, MinC, Quarter});
    endtask

    // Random boxes under each idling pattern, points biased to the faces
    task automatic test_random_boxes();
        int   idle_pat [4];
        int   stall_pat [4];
        acpn_pkg::t_vec lo;
        acpn_pkg::t_vec hi;
        acpn_pkg::t_vec pt;
        bit   in_bias;
        idle_pat  = '{0, 67, 0, 24};
        stall_pat = '{0, 0, 67, 24};
        for (int phase = 0; phase < 4; phase++) begin
            for (int seg = 0; seg < 4; seg++) begin
                for (int a = 0; a < 3; a++)
                    pick_span(lo[a], hi[a]);
                program_box(lo, hi);
                src_idle_pct  = idle_pat[phase];
                snk_stall_pct = stall_pat[phase];
                for (int n = 0; n < 105; n++) begin
                    in_bias = ($urandom_range(1) == 0);
                    for (int a = 0; a < 3; a++)
                        pt[a] = pick_coord(box_lo[a], box_hi[a], in_bias);
                    send_point(pt);
                end
            end
        end
        src_idle_pct  = 0;
        snk_stall_pct = 0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_box();
        test_full_range_box();
        test_inverted_box();
        test_point_box();
        test_random_boxes();
        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_answers.size() == 0) begin
            $display("** aabb_closest_point_normal_top: PASSED **");
        end else begin
            $display("** aabb_closest_point_normal_top: FAILED **");
        end
        $finish;
    end

endmodule

### filelist.f
design/acpn_pkg.sv
design/acpn_diff.sv
design/acpn_score.sv
design/acpn_select.sv
design/aabb_closest_point_normal_top.sv
tb/tb.sv
